FILE: src/fdm_pkg.sv
// Shared types, constants and helpers for the FAT directory entry matcher.
// No dependencies; imported by fat_directory_entry_matcher_top.
package fdm_pkg;

	// Request kinds carried on the input tuser
	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_ENTRY = 2'd1,
		REQ_END   = 2'd2,
		REQ_LOAD  = 2'd3
	} req_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_SEARCH_MODE  = 2'd0,
		CFG_SHORT_LOW    = 2'd1,
		CFG_SHORT_HIGH   = 2'd2,
		CFG_LONG_LENGTH  = 2'd3
	} cfg_idx_t;

	localparam logic StatusFound    = 1'b0;
	localparam logic StatusNotFound = 1'b1;

	localparam logic ModeShort = 1'b0;
	localparam logic ModeLong  = 1'b1;

	// Directory entry byte codes
	localparam logic [7:0] EntryFree     = 8'h00;
	localparam logic [7:0] EntryDeleted  = 8'hE5;
	localparam logic [7:0] EntryKanji05  = 8'h05;
	localparam logic [7:0] AttrLfn       = 8'h0F;
	localparam logic [7:0] AttrHidden    = 8'h02;
	localparam logic [7:0] AttrSystem    = 8'h04;
	localparam logic [7:0] OrderLastFlag = 8'h40;
	localparam logic [7:0] OrderSeqMask  = 8'h1F;

	// Target name store: rows of 13 characters, one row per LFN sequence number
	localparam int LfnChars     = 13;
	localparam int MaxNameChars = 256;
	localparam int RowCount     = (MaxNameChars + LfnChars - 1) / LfnChars;
	localparam int RowAddrW     = $clog2(RowCount);
	localparam int ColW         = $clog2(LfnChars);
	localparam int CountW       = 9;

	localparam int EntryW    = 256;
	localparam int InDataW   = 280;
	localparam int OutDataW  = 160;

	// Byte offset of LFN character j inside the 32-byte entry
	function automatic logic [4:0] lfn_char_off(input logic [ColW-1:0] j);
		logic [4:0] off;
		case (j)
			4'd0:    off = 5'd1;
			4'd1:    off = 5'd3;
			4'd2:    off = 5'd5;
			4'd3:    off = 5'd7;
			4'd4:    off = 5'd9;
			4'd5:    off = 5'd14;
			4'd6:    off = 5'd16;
			4'd7:    off = 5'd18;
			4'd8:    off = 5'd20;
			4'd9:    off = 5'd22;
			4'd10:   off = 5'd24;
			4'd11:   off = 5'd28;
			4'd12:   off = 5'd30;
			default: off = 5'd1;
		endcase
		return off;
	endfunction

	// idx / 13 for an 8-bit index: reciprocal 79/1024 is exact over 0..255
	function automatic logic [RowAddrW-1:0] char_row(input logic [7:0] idx);
		logic [14:0] prod;
		prod = 15'(idx) * 15'd79;
		return RowAddrW'(prod >> 10);
	endfunction

	function automatic logic [ColW-1:0] char_col(input logic [7:0] idx);
		logic [7:0] row_base;
		row_base = 8'(char_row(idx)) * 8'(LfnChars);
		return ColW'(idx - row_base);
	endfunction

endpackage

FILE: src/fdm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fdm_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: src/fat_directory_entry_matcher_top.sv
// FAT directory entry matcher: short 8.3 and long-name lookup over an entry stream.
// Depends on fdm_pkg and fdm_ram (13 column RAMs hold the long target name).
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  s_axis   | in  | tvalid / tready    | tuser: req_type; tdata: entry words, char
//  m_axis   | out | tvalid / tready    | tuser: status; tdata: found entry fields
//  cfg      | in  | cfg_valid / ready  | cfg_index, cfg_data (always ready)
//
// One request per cycle sustained while no result is held on m_axis. The target-row read
// is issued as a request is accepted, so the row arrives with the request in stage 1;
// the compare logic checks 13 characters against it, updates the match state and
// loads the result register when stage 1 advances. A result passes through the
// stage 1 register and the result register before it shows on m_axis.
// Target character loads write the RAM at accept, so later entries see them.
// A held result (m_axis_tready low) stalls stage 2; one more request still
// enters stage 1. arst_n clears control and config; the name RAM is not cleared.
module fat_directory_entry_matcher_top
	import fdm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// request stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// [255:0] entry_word0..3, [263:256] char_index, [279:264] char_value
	input  logic [InDataW-1:0]  s_axis_tdata,
	// [1:0] req_type
	input  logic [1:0]          s_axis_tuser,
	// result stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [63:0] found_name_low, [87:64] found_name_high, [95:88] attributes,
	// [127:96] start_cluster, [159:128] file_size
	output logic [OutDataW-1:0] m_axis_tdata,
	// [0] status
	output logic                m_axis_tuser,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data
);

	// ---------------- configuration registers ----------------
	logic        search_mode_q;
	logic [63:0] short_low_q;
	logic [23:0] short_high_q;
	logic [7:0]  long_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_mode_q <= ModeShort;
			short_low_q   <= '0;
			short_high_q  <= '0;
			long_len_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SEARCH_MODE: search_mode_q <= cfg_data[0];
				CFG_SHORT_LOW:   short_low_q   <= cfg_data;
				CFG_SHORT_HIGH:  short_high_q  <= cfg_data[23:0];
				CFG_LONG_LENGTH: long_len_q    <= cfg_data[7:0];
				default:         ;
			endcase
		end
	end

	// ---------------- handshake / stage control ----------------
	logic              valid_s1;
	req_t              req_s1;
	logic [EntryW-1:0] entry_s1;
	logic              adv;
	logic              in_fire;
	logic              res_load;

	// stage 2 retires stage 1 when the result register is free or draining
	assign adv           = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			req_s1   <= REQ_START;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
			req_s1   <= req_t'(s_axis_tuser);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			entry_s1 <= s_axis_tdata[EntryW-1:0];
		end
	end

	// ---------------- target name RAM ----------------
	logic [7:0]          ld_idx;
	logic [15:0]         ld_val;
	logic [RowAddrW-1:0] ld_row;
	logic [ColW-1:0]     ld_col;
	logic                ram_we;
	logic                ram_re;
	logic [4:0]          rd_seq_m1;
	logic [RowAddrW-1:0] rd_row;
	logic [15:0]         tchar [LfnChars];

	assign ld_idx = s_axis_tdata[263:256];
	assign ld_val = s_axis_tdata[279:264];
	assign ld_row = char_row(ld_idx);
	assign ld_col = char_col(ld_idx);
	assign ram_we = in_fire && (req_t'(s_axis_tuser) == REQ_LOAD);
	assign ram_re = in_fire && (req_t'(s_axis_tuser) == REQ_ENTRY);

	// row = sequence number - 1; rows past the store are never compared
	assign rd_seq_m1 = s_axis_tdata[4:0] - 5'd1;
	assign rd_row    = (5'(rd_seq_m1) < 5'(RowCount)) ? RowAddrW'(rd_seq_m1) : '0;

	for (genvar c = 0; c < LfnChars; c++) begin : g_col
		fdm_ram #(
			.DATA_W (16),
			.DEPTH  (RowCount)
		) u_col_ram (
			.clk     (clk),
			.wr_en   (ram_we && (ld_col == ColW'(c))),
			.wr_addr (ld_row),
			.wr_data (ld_val),
			.rd_en   (ram_re),
			.rd_addr (rd_row),
			.rd_data (tchar[c])
		);
	end

	// ---------------- stage 2: compare and update ----------------
	logic [CountW-1:0] matched_q;
	logic [7:0]        prev_csum_q;
	logic              done_q;

	logic [7:0]        e_order;
	logic [7:0]        e_attr;
	logic [7:0]        e_csum;
	logic [4:0]        e_seq;
	logic              e_skip;
	logic              e_hidden;
	logic              e_is_lfn;
	logic [87:0]       short_tgt;
	logic [CountW-1:0] base;
	logic [LfnChars-1:0] ok;
	logic [3:0]        run_len;
	logic [CountW-1:0] mc_start;
	logic [CountW-1:0] mc_sum;
	logic [CountW-1:0] mc_next;
	logic              lfn_upd;
	logic              hit;
	logic              not_found;

	assign e_order   = entry_s1[7:0];
	assign e_attr    = entry_s1[95:88];
	assign e_csum    = entry_s1[111:104];
	assign e_seq     = 5'(e_order & OrderSeqMask);
	assign e_skip    = (e_order == EntryFree) || (e_order == EntryDeleted);
	assign e_hidden  = ((e_attr & (AttrHidden | AttrSystem)) != 8'h00)
		|| (e_order == EntryKanji05);
	assign e_is_lfn  = (e_attr == AttrLfn);
	assign short_tgt = {short_high_q, short_low_q};
	assign base      = CountW'(e_seq) * CountW'(LfnChars) - CountW'(LfnChars);

	// per-position match: inside the target length and equal characters
	always_comb begin
		for (int j = 0; j < LfnChars; j++) begin
			ok[j] = ((base + CountW'(j)) < {1'b0, long_len_q})
				&& (tchar[j] == entry_s1[8*lfn_char_off(ColW'(j)) +: 16]);
		end
	end

	// length of the leading run of matches
	always_comb begin
		run_len = 4'(LfnChars);
		for (int j = LfnChars - 1; j >= 0; j--) begin
			if (!ok[j]) begin
				run_len = 4'(j);
			end
		end
		if (e_seq == 5'd0) begin
			run_len = 4'd0;
		end
	end

	// chain restarts on a last-in-chain mark, a checksum break or a prior full match
	assign mc_start = ((e_order & OrderLastFlag) != 8'h00 || e_csum != prev_csum_q
		|| matched_q[CountW-1]) ? '0 : matched_q;
	assign mc_sum   = mc_start + CountW'(run_len);
	assign mc_next  = (mc_sum == {1'b0, long_len_q}) ? CountW'(MaxNameChars) : mc_sum;

	always_comb begin
		lfn_upd   = 1'b0;
		hit       = 1'b0;
		not_found = 1'b0;
		if (!done_q) begin
			case (req_s1)
				REQ_END: begin
					not_found = 1'b1;
				end
				REQ_ENTRY: begin
					if (!e_skip) begin
						if (search_mode_q == ModeShort) begin
							hit = !e_hidden && (entry_s1[87:0] == short_tgt);
						end else if (e_is_lfn) begin
							lfn_upd = 1'b1;
						end else begin
							hit = !e_hidden && matched_q[CountW-1];
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign res_load = adv && (hit || not_found);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q   <= '0;
			prev_csum_q <= '0;
			done_q      <= 1'b0;
		end else if (adv) begin
			if (req_s1 == REQ_START) begin
				matched_q <= '0;
				done_q    <= 1'b0;
			end else if (lfn_upd) begin
				matched_q   <= mc_next;
				prev_csum_q <= e_csum;
			end else if (hit || not_found) begin
				done_q <= 1'b1;
				if (hit) begin
					matched_q <= '0;
				end
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (res_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_axis_tuser <= hit ? StatusFound : StatusNotFound;
			if (hit) begin
				m_axis_tdata <= {entry_s1[255:224],                      // file size
					entry_s1[175:160], entry_s1[223:208],            // cluster hi, lo
					e_attr, entry_s1[87:0]};
			end else begin
				m_axis_tdata <= '0;
			end
		end
	end

	// ---------------- checks ----------------
	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> done_q)
		else $error("search not closed after a result");

	a_no_result_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !done_q)
		else $error("result produced after search closed");

	a_no_overwrite_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |-> !in_fire)
		else $error("stage 1 overwritten while stalled");

	a_ram_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("RAM read and write in one cycle");

	a_match_range: assert property (@(posedge clk) disable iff (!arst_n)
		matched_q <= CountW'(MaxNameChars + LfnChars - 1))
		else $error("matched count out of range");

endmodule
